/* hdl/msb_first_bit_stream_buffer_unit_defines.svh */
// Assertion macros for the MSB-first bit stream buffer.
`ifndef MSB_FIRST_BIT_STREAM_BUFFER_UNIT_DEFINES_SVH
`define MSB_FIRST_BIT_STREAM_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BSB_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bsb_pkg.sv */
// Shared types and constants for the MSB-first bit stream buffer.
`default_nettype none

package bsb_pkg;

	localparam int DEF_STORE_BYTES = 256;
	localparam int DATA_W          = 8;
	localparam int CNT_W           = 4;
	localparam int POS_W           = 12;
	localparam int MAX_BITS        = 8;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_WR_OVF = 2'd1,
		ST_RD_OVF = 2'd2
	} status_t;

endpackage

`default_nettype wire

/* hdl/bsb_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none

module bsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

`default_nettype wire

/* hdl/msb_first_bit_stream_buffer_unit.sv */
// Top level of the MSB-first bit stream buffer: packer, unpacker and byte store.
`default_nettype none

// MSB-first bit stream buffer. Each input word either appends 1..8 low-aligned
// bits of data at the write bit pointer (cmd = 0) or takes 1..8 bits at the read
// bit pointer (cmd = 1), returned right-aligned in read_data. bit_count above 8 is
// treated as 8; a count of zero does nothing. A write that would run past
// STORE_BYTES*8 bits is dropped with status 1, a read asking for more bits than
// have been written and not yet read is dropped with status 2; neither moves a
// pointer. Every input word gives exactly one result word carrying the low 12 bits
// of both pointers after the word. Throughput is one word per clock while the
// result channel is not stalled. Each word passes the input register, where the
// registered read of the byte store is taken, and then the result register. The
// byte being filled lives in a register and is written to the store once complete,
// so the store needs no read-modify-write. The result register lets the block take
// a new word while a finished result is still stalled. No clearing pass after
// reset: the store only ever serves bytes that were written.

`include "msb_first_bit_stream_buffer_unit_defines.svh"

module msb_first_bit_stream_buffer_unit
	import bsb_pkg::*;
#(
	parameter int STORE_BYTES = DEF_STORE_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input channel
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic              cmd,
	input  wire logic [DATA_W-1:0] data,
	input  wire logic [CNT_W-1:0]  bit_count,
	// result channel
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic      [DATA_W-1:0] read_data,
	output logic      [1:0]        status,
	output logic      [POS_W-1:0]  write_position,
	output logic      [POS_W-1:0]  read_position
);

	localparam int CAP_BITS = STORE_BYTES * 8;
	localparam int PW       = $clog2(CAP_BITS + 1);   // pointer width
	localparam int AW       = $clog2(STORE_BYTES);    // byte address width
	localparam int BW       = PW - 3;                 // byte index width
	localparam int PW_EXT   = (PW > POS_W) ? PW : POS_W;

	// ------------------------------------------------------------------
	// Handshake: stage 1 loads when empty or when it drains into the
	// result register.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic out_adv;
	logic s1_load;
	logic item_accept;

	assign out_adv     = !result_valid || !result_stall;
	assign s1_load     = !valid_s1 || out_adv;
	assign item_stall  = !s1_load;
	assign item_accept = item_valid && s1_load;

	// ------------------------------------------------------------------
	// Pointers and the partially filled write byte
	// ------------------------------------------------------------------
	logic [PW-1:0]     wp_q, rp_q;
	logic [DATA_W-1:0] acc_q;

	logic [CNT_W-1:0]  n;
	logic [PW-1:0]     n_ext;
	logic [PW-1:0]     free_bits, avail_bits;
	logic              wr_ovf, rd_ovf;
	logic              is_read;
	logic              wr_go, rd_go;
	status_t           status_new;
	logic [PW-1:0]     wp_next, rp_next;
	logic [PW_EXT-1:0] wp_next_ext, rp_next_ext;

	assign n          = (bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bit_count;
	assign n_ext      = PW'(n);
	assign free_bits  = PW'(CAP_BITS) - wp_q;
	assign avail_bits = wp_q - rp_q;
	assign wr_ovf     = n_ext > free_bits;
	assign rd_ovf     = n_ext > avail_bits;
	assign is_read    = (cmd == CMD_READ);

	always_comb begin
		status_new = ST_OK;
		if (n != '0) begin
			if (!is_read && wr_ovf) begin
				status_new = ST_WR_OVF;
			end else if (is_read && rd_ovf) begin
				status_new = ST_RD_OVF;
			end
		end
	end

	assign wr_go = item_accept && !is_read && (n != '0) && !wr_ovf;
	assign rd_go = item_accept && is_read && (n != '0) && !rd_ovf;

	assign wp_next     = wr_go ? (wp_q + n_ext) : wp_q;
	assign rp_next     = rd_go ? (rp_q + n_ext) : rp_q;
	assign wp_next_ext = PW_EXT'(wp_next);
	assign rp_next_ext = PW_EXT'(rp_next);

	// ------------------------------------------------------------------
	// Packer: align the new bits under the write pointer
	// ------------------------------------------------------------------
	logic [2:0]          wmod;
	logic [DATA_W-1:0]   s_aln;       // new bits, MSB-aligned
	logic [2*DATA_W-1:0] sh16;        // upper: current byte, lower: spill
	logic [CNT_W-1:0]    wend;
	logic                byte_done;
	logic [DATA_W-1:0]   merged;
	logic                ram_we;
	logic [AW-1:0]       waddr;

	assign wmod      = wp_q[2:0];
	assign s_aln     = data << (CNT_W'(MAX_BITS) - n);
	assign sh16      = {s_aln, {DATA_W{1'b0}}} >> wmod;
	assign wend      = CNT_W'(wmod) + n;
	assign byte_done = wend >= CNT_W'(MAX_BITS);
	// a write on a byte boundary starts the byte fresh
	assign merged    = ((wmod == 3'd0) ? {DATA_W{1'b0}} : acc_q) | sh16[2*DATA_W-1:DATA_W];
	assign ram_we    = wr_go && byte_done;
	assign waddr     = wp_q[AW+2:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			acc_q <= '0;
		end else begin
			wp_q <= wp_next;
			rp_q <= rp_next;
			if (wr_go) begin
				acc_q <= byte_done ? sh16[DATA_W-1:0] : merged;
			end
		end
	end

	// ------------------------------------------------------------------
	// Unpacker, stage 1: fetch the two bytes under the read pointer.
	// A byte still in acc_q is taken from there instead of the store.
	// ------------------------------------------------------------------
	logic [BW-1:0]   rbyte, wbyte;
	logic [BW:0]     rbyte_inc;
	logic [AW-1:0]   raddr0, raddr1;
	logic            sel0, sel1;

	assign rbyte     = rp_q[PW-1:3];
	assign wbyte     = wp_q[PW-1:3];
	assign rbyte_inc = {1'b0, rbyte} + 1'b1;
	assign sel0      = (rbyte == wbyte);
	assign sel1      = (rbyte_inc == {1'b0, wbyte});
	assign raddr0    = rp_q[AW+2:3];
	assign raddr1    = raddr0 + 1'b1;

	logic [DATA_W-1:0] rdata0, rdata1;

	bsb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr),
		.wdata  (merged),
		.re     (s1_load),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	logic              rd_s1;
	logic [2:0]        rmod_s1;
	logic [CNT_W-1:0]  rn_s1;
	logic              sel0_s1, sel1_s1;
	logic [DATA_W-1:0] acc_s1;
	status_t           status_s1;
	logic [POS_W-1:0]  wpos_s1, rpos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rd_s1     <= rd_go;
			rmod_s1   <= rp_q[2:0];
			rn_s1     <= n;
			sel0_s1   <= sel0;
			sel1_s1   <= sel1;
			acc_s1    <= acc_q;
			status_s1 <= status_new;
			wpos_s1   <= wp_next_ext[POS_W-1:0];
			rpos_s1   <= rp_next_ext[POS_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Unpacker, stage 2: shift the byte pair and right-align the bits
	// ------------------------------------------------------------------
	logic [DATA_W-1:0]   b0, b1;
	logic [2*DATA_W-1:0] win;
	logic [DATA_W-1:0]   taken;

	assign b0    = sel0_s1 ? acc_s1 : rdata0;
	assign b1    = sel1_s1 ? acc_s1 : rdata1;
	assign win   = {b0, b1} << rmod_s1;
	// bits of the second byte fall off here when the read does not spill
	assign taken = win[2*DATA_W-1:DATA_W] >> (CNT_W'(MAX_BITS) - rn_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			read_data      <= rd_s1 ? taken : {DATA_W{1'b0}};
			status         <= status_s1;
			write_position <= wpos_s1;
			read_position  <= rpos_s1;
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`BSB_ASSERT_HOLDS(a_wp_in_store, 1'b1, wp_q <= PW'(CAP_BITS), "write pointer past store")
	`BSB_ASSERT_HOLDS(a_rp_behind_wp, 1'b1, rp_q <= wp_q, "read pointer ahead of write pointer")
	`BSB_ASSERT_NEXT(a_reject_keeps, item_accept && (status_new != ST_OK),
		$stable(wp_q) && $stable(rp_q) && $stable(acc_q), "rejected word moved state")

endmodule

`default_nettype wire
